>>> design/rhos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhos_pkg
// shared types and constants of the radial hit order sorter
// ----------------------------------------------------------------------------
package rhos_pkg;

    // store capacity in hits
    localparam int MAX_HITS = 64;
    localparam int ADDR_W   = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int CNT_W    = $clog2(MAX_HITS + 1);

    localparam int ID_W     = 16;
    localparam int RAD_W    = 16;
    localparam int WIRE_W   = 9;
    localparam int LAYER_SH = 8;
    localparam int ENTRY_W  = ID_W + RAD_W + WIRE_W;
    localparam int S_DATA_W = ((ENTRY_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_NEG = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_TH    = CFG_IDX_W'(1);
    localparam logic [WIRE_W-1:0]    WRAP_TH_RESET  = WIRE_W'(100);

    typedef struct packed {
        logic [WIRE_W-1:0] wire_number;
        logic [RAD_W-1:0]  radius;
        logic [ID_W-1:0]   hit_id;
    } t_entry;

    typedef struct packed {
        logic              charge_negative;
        logic [WIRE_W-1:0] wrap_threshold;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_PLACE,
        ST_ERD,
        ST_EOUT
    } t_state;

endpackage

>>> design/rhos_key_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhos_key_compare
// ordering test: is hit a placed before hit b
// ----------------------------------------------------------------------------
module rhos_key_compare (
    input  rhos_pkg::t_entry i_a,
    input  rhos_pkg::t_entry i_b,
    input  rhos_pkg::t_cfg   i_cfg,
    output logic             o_less
);
    import rhos_pkg::*;

    logic same_layer;
    logic a_zero_b_high;
    logic a_high_b_zero;

    assign same_layer    = (i_a.radius[RAD_W-1:LAYER_SH] == i_b.radius[RAD_W-1:LAYER_SH]);
    assign a_zero_b_high = (i_a.wire_number == '0) && (i_b.wire_number > i_cfg.wrap_threshold);
    assign a_high_b_zero = (i_a.wire_number > i_cfg.wrap_threshold) && (i_b.wire_number == '0);

    always_comb begin
        if (!same_layer) begin
            o_less = (i_a.radius < i_b.radius);
        end else if (a_zero_b_high) begin
            o_less = !i_cfg.charge_negative;
        end else if (a_high_b_zero) begin
            o_less = i_cfg.charge_negative;
        end else if (i_cfg.charge_negative) begin
            o_less = (i_a.wire_number < i_b.wire_number);
        end else begin
            o_less = (i_a.wire_number > i_b.wire_number);
        end
    end

endmodule

>>> design/radial_hit_order_sorter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_hit_order_sorter_unit
// collects one track's hits in a sorted store, emits the ids on the final hit
// ----------------------------------------------------------------------------
// a hit walks from the end of the store until a stored entry stops it or it
//   reaches the front, with one store read and one key compare per step;
//   each entry it passes moves up one slot; when the store is full it is dropped
// each result is a store read into the output register, held through stalls
// input is not ready while a hit is placed or results are emitted
// synchronous active-low reset clears count, overflow flag, state and config registers;
//   the hit store itself is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
module radial_hit_order_sorter_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side, tdata: hit_id[15:0], radius[31:16], wire_number[40:32], zero pad
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [rhos_pkg::S_DATA_W-1:0]       i_s_tdata,
    input  logic                                i_s_tlast,  // final_hit
    // master side, tdata: sorted_hit_id[15:0]
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [rhos_pkg::ID_W-1:0]           o_m_tdata,
    output logic                                o_m_tlast,  // final_result
    output logic                                o_m_tuser,  // tuser: overflow
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rhos_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rhos_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rhos_pkg::*;

    // sequencer state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;     // entries held
    logic [CNT_W-1:0]   r_ptr, n_ptr;         // slot the new hit would take
    logic [CNT_W-1:0]   r_out_idx, n_out_idx; // next entry to emit
    logic               r_dropped, n_dropped;
    logic               r_final, n_final;
    t_entry             r_new;                // hit being placed
    t_cfg               r_cfg;

    // hit store, single write and single registered read
    t_entry             r_mem [MAX_HITS];
    t_entry             r_rd;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    t_entry             wr_data;

    logic               s_accept;
    logic               m_accept;
    logic               less;
    logic [CNT_W-1:0]   ptr_dec;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign m_accept    = o_m_tvalid && i_m_tready;
    assign ptr_dec     = r_ptr - CNT_W'(1);

    // output register is the store read register, held while in the emit state
    assign o_m_tvalid = (r_state == ST_EOUT);
    assign o_m_tdata  = r_rd.hit_id;
    assign o_m_tlast  = (r_out_idx == r_count - CNT_W'(1));
    assign o_m_tuser  = r_dropped;

    // the one compare unit: new hit against the entry just read
    rhos_key_compare u_cmp (
        .i_a    (r_new),
        .i_b    (r_rd),
        .i_cfg  (r_cfg),
        .o_less (less)
    );

    // configuration registers, taken in any state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.charge_negative <= 1'b0;
            r_cfg.wrap_threshold  <= WRAP_TH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CHARGE_NEG: r_cfg.charge_negative <= i_cfg_data[0];
                CFG_WRAP_TH:    r_cfg.wrap_threshold  <= i_cfg_data[WIRE_W-1:0];
                default: ;
            endcase
        end
    end

    // incoming hit latch
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_new <= t_entry'(i_s_tdata[ENTRY_W-1:0]);
        end
    end

    // store ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_ptr     <= '0;
            r_out_idx <= '0;
            r_dropped <= 1'b0;
            r_final   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_out_idx <= n_out_idx;
            r_dropped <= n_dropped;
            r_final   <= n_final;
        end
    end

    // sequencer: insertion pass, then emission on a final hit
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_out_idx = r_out_idx;
        n_dropped = r_dropped;
        n_final   = r_final;
        rd_en     = 1'b0;
        rd_addr   = ptr_dec[ADDR_W-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_ptr[ADDR_W-1:0];
        wr_data   = r_new;

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_final   = i_s_tlast;
                    n_out_idx = '0;
                    n_ptr     = r_count;
                    if (r_count == CNT_W'(MAX_HITS)) begin
                        // store full: hit dropped
                        n_dropped = 1'b1;
                        n_state   = i_s_tlast ? ST_ERD : ST_IDLE;
                    end else if (r_count == '0) begin
                        n_state = ST_PLACE;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                rd_en   = 1'b1;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                wr_en = 1'b1;
                if (less) begin
                    // move the stored entry up one slot
                    wr_data = r_rd;
                    n_ptr   = ptr_dec;
                    n_state = (ptr_dec == '0) ? ST_PLACE : ST_RD;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    n_state = r_final ? ST_ERD : ST_IDLE;
                end
            end
            ST_PLACE: begin
                wr_en   = 1'b1;
                n_count = r_count + CNT_W'(1);
                n_state = r_final ? ST_ERD : ST_IDLE;
            end
            ST_ERD: begin
                rd_en   = 1'b1;
                rd_addr = r_out_idx[ADDR_W-1:0];
                n_state = ST_EOUT;
            end
            ST_EOUT: begin
                if (m_accept) begin
                    if (o_m_tlast) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_state   = ST_IDLE;
                    end else begin
                        n_out_idx = r_out_idx + CNT_W'(1);
                        n_state   = ST_ERD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/rhos_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhos_checker
// port-level checks of the radial hit order sorter
// ----------------------------------------------------------------------------
module rhos_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            i_s_tlast,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [rhos_pkg::ID_W-1:0]       o_m_tdata,
    input logic                            o_m_tlast,
    input logic                            o_m_tuser
);

    // hits are never taken while results are pending
    a_serial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while a result is offered");

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser)))
        else $error("stalled result changed");

    // the last result of a track closes the emission
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> !o_m_tvalid)
        else $error("result offered after the last one");

    // a non-final hit causes no result right away
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tlast) |=> !o_m_tvalid)
        else $error("result offered after a non-final hit");

endmodule

bind radial_hit_order_sorter_unit rhos_checker u_rhos_checker (.*);

>>> sim/radial_hit_order_sorter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_hit_order_sorter_unit_tb
// self-checking bench for the radial hit order sorter: tracks of hits go in on
// the slave stream, each accepted hit is put through a behavioural insertion
// sort with the same key rules, and every sorted id that comes out of the
// master stream is checked against the oldest id still due
// ----------------------------------------------------------------------------
module radial_hit_order_sorter_unit_tb;

    import rhos_pkg::*;

    localparam int CLK_PERIOD     = 20;
    // settle time for a hit passing 63 stored entries, so this covers
    // any placement still running after the last sorted id has left
    localparam int SETTLE_CYCLES  = 200;
    // cycles with no transaction on any channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int NUM_PHASES     = 6;
    // register index outside the list, must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(8'hFE);

    // one hit waiting to be sent
    typedef struct {
        t_entry hit;
        logic   is_last;
    } t_hit_txn;

    // one sorted id the block still owes us
    typedef struct {
        logic [ID_W-1:0] id;
        logic            last;
        logic            ovf;
    } t_sorted_id;

    // ------------------------------------------------------------------------
    // block ports, every input known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0]   i_s_tdata   = '0;
    logic                  i_s_tlast   = 1'b0;
    logic                  i_m_tready  = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [ID_W-1:0]       o_m_tdata;
    logic                  o_m_tlast;
    logic                  o_m_tuser;
    logic                  o_cfg_ready;

    // ------------------------------------------------------------------------
    // predictor state: our own sorted store and register copies
    // ------------------------------------------------------------------------
    t_entry            order_store [MAX_HITS];
    int unsigned       stored_hits   = 0;
    logic              hits_dropped  = 1'b0;
    logic              cfg_negative  = 1'b0;
    logic [WIRE_W-1:0] cfg_threshold = WRAP_TH_RESET;

    t_hit_txn    pending_hits [$];
    t_hit_txn    on_bus;
    t_sorted_id  due_ids [$];
    int unsigned hits_in_flight = 0;
    int unsigned fail_count     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned quiet_cycles   = 0;

    radial_hit_order_sorter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // hit_id[15:0], radius[31:16], wire_number[40:32]
        .i_s_tlast   (i_s_tlast),   // final_hit
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // sorted_hit_id[15:0]
        .o_m_tlast   (o_m_tlast),   // final_result
        .o_m_tuser   (o_m_tuser),   // overflow
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // sort key: does hit a go in front of hit b
    // ------------------------------------------------------------------------
    function automatic logic hit_sorts_first(t_entry a, t_entry b);
        // different whole-centimetre layer: plain radius order
        if (a.radius[RAD_W-1:LAYER_SH] != b.radius[RAD_W-1:LAYER_SH])
            return a.radius < b.radius;
        // same layer: the wrap between wire 0 and a high wire wins over wire order
        if (cfg_negative) begin
            if (a.wire_number == '0 && b.wire_number > cfg_threshold) return 1'b0;
            if (a.wire_number > cfg_threshold && b.wire_number == '0) return 1'b1;
            return a.wire_number < b.wire_number;
        end
        if (a.wire_number == '0 && b.wire_number > cfg_threshold) return 1'b1;
        if (a.wire_number > cfg_threshold && b.wire_number == '0) return 1'b0;
        return a.wire_number > b.wire_number;
    endfunction

    // place one accepted hit; on the last hit of a track queue the sorted ids
    function automatic void insert_hit_sorted(t_entry hit, logic is_last);
        int unsigned slot;
        t_sorted_id  due;
        if (stored_hits >= MAX_HITS) begin
            hits_dropped = 1'b1;
        end else begin
            // walk towards the front only while strictly ahead, so ties keep arrival order
            slot = stored_hits;
            while (slot > 0 && hit_sorts_first(hit, order_store[slot-1])) begin
                order_store[slot] = order_store[slot-1];
                slot--;
            end
            order_store[slot] = hit;
            stored_hits++;
        end
        if (is_last) begin
            for (int unsigned k = 0; k < stored_hits; k++) begin
                due = '{id: order_store[k].hit_id,
                        last: (k + 1 == stored_hits),
                        ovf: hits_dropped};
                due_ids.insert(due_ids.size(), due);
            end
            stored_hits  = 0;
            hits_dropped = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%0t: %s", $time, what);
    endtask

    function automatic void queue_hit(input logic [ID_W-1:0] id, input logic [RAD_W-1:0] rad,
                                      input logic [WIRE_W-1:0] wire_no, input logic is_last);
        t_hit_txn txn;
        txn = '{hit: '{wire_number: wire_no, radius: rad, hit_id: id}, is_last: is_last};
        pending_hits.insert(pending_hits.size(), txn);
        hits_in_flight++;
    endfunction

    // same-layer tracks: wire order, wraps on both sides of the threshold,
    // a repeated wire for stability, and a layer boundary that beats wire order
    function automatic void queue_wire_tracks();
        queue_hit(16'd10, 16'h0510, 9'd3,   1'b0);
        queue_hit(16'd11, 16'h0580, 9'd200, 1'b0);
        queue_hit(16'd12, 16'h0501, 9'd0,   1'b0);
        queue_hit(16'd13, 16'h05FF, 9'd50,  1'b0);
        queue_hit(16'd14, 16'h0540, 9'd3,   1'b0);
        queue_hit(16'd15, 16'h0530, 9'd100, 1'b0);  // equal to threshold, no wrap
        queue_hit(16'd16, 16'h0520, 9'd101, 1'b1);
        queue_hit(16'd20, 16'h06FF, 9'd1,   1'b0);
        queue_hit(16'd21, 16'h0700, 9'd400, 1'b1);
    endfunction

    // random tracks, mostly short, radii drawn from a few layers per track so
    // that wire order and the wrap rule get exercised
    function automatic void queue_random_tracks(input int unsigned n_items);
        int unsigned       made;
        int unsigned       len;
        logic [7:0]        layers [3];
        logic [WIRE_W-1:0] wire_no;
        logic [WIRE_W-1:0] prev_wire;
        logic [RAD_W-1:0]  rad;
        made      = 0;
        prev_wire = '0;
        while (made < n_items) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
            foreach (layers[j]) layers[j] = 8'($urandom_range(255));
            for (int unsigned k = 0; k < len; k++) begin
                case ($urandom_range(5))
                    0: wire_no = '0;
                    1: wire_no = (cfg_threshold < 9'd511) ?
                                 WIRE_W'($urandom_range(511, cfg_threshold + 1)) :
                                 WIRE_W'($urandom_range(511));
                    2: wire_no = prev_wire;
                    default: wire_no = WIRE_W'($urandom_range(511));
                endcase
                rad = ($urandom_range(7) == 0) ? RAD_W'($urandom_range(16'hFFFF)) :
                      {layers[$urandom_range(2)], 8'($urandom_range(255))};
                queue_hit(ID_W'($urandom_range(16'hFFFF)), rad, wire_no, k + 1 == len);
                prev_wire = wire_no;
            end
            made += len;
        end
    endfunction

    // one register write, called just after a rising edge; lowers valid and waits
    // for an edge so back-to-back writes never stack two assignments in one step
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_CHARGE_NEG: cfg_negative  = value[0];
            CFG_WRAP_TH:    cfg_threshold = value[WIRE_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // hit driver: holds each hit until its transaction completes
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                insert_hit_sorted(on_bus.hit, on_bus.is_last);
                hits_in_flight--;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_hits.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = pending_hits.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= S_DATA_W'(on_bus.hit);
                    i_s_tlast  <= on_bus.is_last;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: random back-pressure, field-by-field compare
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_sorted_id want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (due_ids.size() == 0) begin
                    report_mismatch($sformatf("sorted id 0x%0h arrived with none due",
                                              o_m_tdata));
                end else begin
                    want = due_ids.pop_front();
                    if (o_m_tdata !== want.id)
                        report_mismatch($sformatf("sorted id: got 0x%0h, want 0x%0h",
                                                  o_m_tdata, want.id));
                    if (o_m_tlast !== want.last)
                        report_mismatch($sformatf("last flag of id 0x%0h: got %b, want %b",
                                                  want.id, o_m_tlast, want.last));
                    if (o_m_tuser !== want.ovf)
                        report_mismatch($sformatf("overflow flag of id 0x%0h: got %b, want %b",
                                                  want.id, o_m_tuser, want.ovf));
                end
            end
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: any transaction on any channel restarts the count
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // phases: each starts with the block drained and settled, then sets the
    // registers, the idling pattern and the stimulus; the extra pass at the
    // end only drains
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase <= NUM_PHASES; phase++) begin
            while (hits_in_flight != 0 || due_ids.size() != 0) @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);

            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase

            case (phase)
                0: begin
                    // reset settings: positive charge, threshold 100
                    queue_hit(16'hFFFF, 16'hFFFF, 9'd511, 1'b1);  // lone hit, all ones
                    queue_hit(16'd1, 16'h0300, 9'd5, 1'b0);        // plain radius order
                    queue_hit(16'd2, 16'h0100, 9'd7, 1'b0);
                    queue_hit(16'd3, 16'h02FF, 9'd9, 1'b0);
                    queue_hit(16'd0, 16'h0000, 9'd0, 1'b1);        // all zeros
                    queue_wire_tracks();
                end
                1: begin
                    write_register(CFG_CHARGE_NEG, 9'd1);
                    queue_wire_tracks();
                end
                2: begin
                    // threshold 0: wire 0 wraps against every other wire
                    write_register(CFG_CHARGE_NEG, 9'd0);
                    write_register(CFG_WRAP_TH, 9'd0);
                    queue_random_tracks(4);
                end
                3: begin
                    // threshold at the top: the wrap can never apply
                    write_register(CFG_CHARGE_NEG, 9'd1);
                    write_register(CFG_WRAP_TH, 9'd511);
                    queue_random_tracks(4);
                    // overfull track, the final hit itself is among the dropped
                    for (int k = 0; k < MAX_HITS + 1; k++)
                        queue_hit(ID_W'($urandom_range(16'hFFFF)),
                                  {8'($urandom_range(3)), 8'($urandom_range(255))},
                                  WIRE_W'($urandom_range(511)), k == MAX_HITS);
                end
                4: begin
                    // spare index ignored, charge takes bit 0 only
                    write_register(CFG_IDX_SPARE, 9'h155);
                    write_register(CFG_CHARGE_NEG, 9'h1FE);
                    write_register(CFG_WRAP_TH, CFG_DATA_W'($urandom_range(511)));
                    queue_random_tracks(4);
                end
                5: begin
                    write_register(CFG_IDX_W'($urandom_range(255, 2)),
                                   CFG_DATA_W'($urandom_range(511)));
                    write_register(CFG_CHARGE_NEG, 9'd1);
                    write_register(CFG_WRAP_TH, CFG_DATA_W'($urandom_range(510, 1)));
                    queue_random_tracks(4);
                end
                default: ;
            endcase
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
design/rhos_pkg.sv
design/rhos_key_compare.sv
design/radial_hit_order_sorter_unit.sv
design/rhos_checker.sv
sim/radial_hit_order_sorter_unit_tb.sv
